### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is high
`define TMDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion, checked through reset as well
`define TMDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tmdc_pkg.sv
// types, codes and default font and palette tables of the text mode display controller
package tmdc_pkg;

   localparam int FONT_WORDS   = 256;
   localparam int PALETTE_SIZE = 16;
   localparam int FONT_AW      = $clog2(FONT_WORDS);
   localparam int PAL_AW       = $clog2(PALETTE_SIZE);

   typedef logic [2:0]  code_type;
   typedef logic [15:0] word_type;
   typedef logic [8:0]  cell_pos_type;
   typedef logic [7:0]  table_idx_type;
   typedef logic [6:0]  coord_type;
   typedef logic [7:0]  channel_type;
   typedef logic [3:0]  pal_idx_type;
   typedef logic [11:0] rgb_type;
   typedef logic [23:0] ticks_type;

   localparam ticks_type TICKS_RESET = 24'd100000;

   typedef enum logic [1:0] {
      PWR_OFF      = 2'd0,
      PWR_STARTING = 2'd1,
      PWR_ACTIVE   = 2'd2
   } power_state_type;

   typedef enum logic [2:0] {
      REQ_COMMAND      = 3'd0,
      REQ_TICK         = 3'd1,
      REQ_RENDER       = 3'd2,
      REQ_LOAD_FONT    = 3'd3,
      REQ_LOAD_PALETTE = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      CMD_MAP_SCREEN  = 3'd0,
      CMD_MAP_FONT    = 3'd1,
      CMD_MAP_PALETTE = 3'd2,
      CMD_BORDER      = 3'd3
   } command_type;

   localparam word_type GLYPH_ROM [FONT_WORDS] = '{
      16'hb79e, 16'h388e, 16'h722c, 16'h75f4, 16'h19bb, 16'h7f8f, 16'h85f9, 16'hb158,
      16'h242e, 16'h2400, 16'h082a, 16'h0800, 16'h0008, 16'h0000, 16'h0808, 16'h0808,
      16'h00ff, 16'h0000, 16'h00f8, 16'h0808, 16'h08f8, 16'h0000, 16'h080f, 16'h0000,
      16'h000f, 16'h0808, 16'h00ff, 16'h0808, 16'h08f8, 16'h0808, 16'h08ff, 16'h0000,
      16'h080f, 16'h0808, 16'h08ff, 16'h0808, 16'h6633, 16'h99cc, 16'h9933, 16'h66cc,
      16'hfef8, 16'he080, 16'h7f1f, 16'h0701, 16'h0107, 16'h1f7f, 16'h80e0, 16'hf8fe,
      16'h5500, 16'haa00, 16'h55aa, 16'h55aa, 16'hffaa, 16'hff55, 16'h0f0f, 16'h0f0f,
      16'hf0f0, 16'hf0f0, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'hffff,
      16'h0000, 16'h0000, 16'h005f, 16'h0000, 16'h0300, 16'h0300, 16'h3e14, 16'h3e00,
      16'h266b, 16'h3200, 16'h611c, 16'h4300, 16'h3629, 16'h7650, 16'h0002, 16'h0100,
      16'h1c22, 16'h4100, 16'h4122, 16'h1c00, 16'h1408, 16'h1400, 16'h081c, 16'h0800,
      16'h4020, 16'h0000, 16'h0808, 16'h0800, 16'h0040, 16'h0000, 16'h601c, 16'h0300,
      16'h3e49, 16'h3e00, 16'h427f, 16'h4000, 16'h6259, 16'h4600, 16'h2249, 16'h3600,
      16'h0f08, 16'h7f00, 16'h2745, 16'h3900, 16'h3e49, 16'h3200, 16'h6119, 16'h0700,
      16'h3649, 16'h3600, 16'h2649, 16'h3e00, 16'h0024, 16'h0000, 16'h4024, 16'h0000,
      16'h0814, 16'h2200, 16'h1414, 16'h1400, 16'h2214, 16'h0800, 16'h0259, 16'h0600,
      16'h3e59, 16'h5e00, 16'h7e09, 16'h7e00, 16'h7f49, 16'h3600, 16'h3e41, 16'h2200,
      16'h7f41, 16'h3e00, 16'h7f49, 16'h4100, 16'h7f09, 16'h0100, 16'h3e41, 16'h7a00,
      16'h7f08, 16'h7f00, 16'h417f, 16'h4100, 16'h2040, 16'h3f00, 16'h7f08, 16'h7700,
      16'h7f40, 16'h4000, 16'h7f06, 16'h7f00, 16'h7f01, 16'h7e00, 16'h3e41, 16'h3e00,
      16'h7f09, 16'h0600, 16'h3e61, 16'h7e00, 16'h7f09, 16'h7600, 16'h2649, 16'h3200,
      16'h017f, 16'h0100, 16'h3f40, 16'h7f00, 16'h1f60, 16'h1f00, 16'h7f30, 16'h7f00,
      16'h7708, 16'h7700, 16'h0778, 16'h0700, 16'h7149, 16'h4700, 16'h007f, 16'h4100,
      16'h031c, 16'h6000, 16'h417f, 16'h0000, 16'h0201, 16'h0200, 16'h8080, 16'h8000,
      16'h0001, 16'h0200, 16'h2454, 16'h7800, 16'h7f44, 16'h3800, 16'h3844, 16'h2800,
      16'h3844, 16'h7f00, 16'h3854, 16'h5800, 16'h087e, 16'h0900, 16'h4854, 16'h3c00,
      16'h7f04, 16'h7800, 16'h047d, 16'h0000, 16'h2040, 16'h3d00, 16'h7f10, 16'h6c00,
      16'h017f, 16'h0000, 16'h7c18, 16'h7c00, 16'h7c04, 16'h7800, 16'h3844, 16'h3800,
      16'h7c14, 16'h0800, 16'h0814, 16'h7c00, 16'h7c04, 16'h0800, 16'h4854, 16'h2400,
      16'h043e, 16'h4400, 16'h3c40, 16'h7c00, 16'h1c60, 16'h1c00, 16'h7c30, 16'h7c00,
      16'h6c10, 16'h6c00, 16'h4c50, 16'h3c00, 16'h6454, 16'h4c00, 16'h0836, 16'h4100,
      16'h0077, 16'h0000, 16'h4136, 16'h0800, 16'h0201, 16'h0201, 16'h0205, 16'h0200
   };

   localparam rgb_type COLOR_ROM [PALETTE_SIZE] = '{
      12'h000, 12'h00a, 12'h0a0, 12'h0aa, 12'ha00, 12'ha0a, 12'ha50, 12'haaa,
      12'h555, 12'h55f, 12'h5f5, 12'h5ff, 12'hf55, 12'hf5f, 12'hff5, 12'hfff
   };

   function automatic word_type font_rom(input logic [FONT_AW-1:0] idx);
      return GLYPH_ROM[idx];
   endfunction

   function automatic rgb_type palette_rom(input logic [PAL_AW-1:0] idx);
      return COLOR_ROM[idx];
   endfunction

   // nibble times 0x11
   function automatic channel_type widen_nibble(input logic [3:0] nib);
      return {nib, nib};
   endfunction

endpackage

### hdl/tmdc_if.sv
// valid/ready channel interfaces of the text mode display controller
interface tmdc_req_if;
   logic                   valid;
   logic                   ready;
   tmdc_pkg::code_type      req_type;
   tmdc_pkg::code_type      command;
   tmdc_pkg::word_type      operand;
   tmdc_pkg::cell_pos_type  position;
   tmdc_pkg::table_idx_type table_index;

   modport source (output valid, req_type, command, operand, position, table_index,
                   input ready);
   modport sink   (input valid, req_type, command, operand, position, table_index,
                   output ready);
endinterface

interface tmdc_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  pixel_valid;
   tmdc_pkg::coord_type    pixel_x;
   tmdc_pkg::coord_type    pixel_y;
   tmdc_pkg::channel_type  red;
   tmdc_pkg::channel_type  green;
   tmdc_pkg::channel_type  blue;
   logic                  last;
   logic                  display_active;
   logic                  blink_phase;
   tmdc_pkg::pal_idx_type  border_index;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, red, green, blue, last,
                          display_active, blink_phase, border_index,
                   input ready);
   modport sink   (input valid, pixel_valid, pixel_x, pixel_y, red, green, blue, last,
                         display_active, blink_phase, border_index,
                   output ready);
endinterface

interface tmdc_csr_if;
   logic                valid;
   logic                ready;
   tmdc_pkg::ticks_type wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

### hdl/text_mode_display_controller.sv
// text mode display controller: power state, blink timing and cell-to-pixel rendering
//
// A rendered cell comes out as 32 pixel beats on rsp_ch, one per cycle while rsp_ch.ready
// is high; the 5-bit beat counter of the output register sets the number of beats. Every
// other item (command, tick, font or palette load, and a render that draws nothing) gives
// one marker beat, so such items flow at one per cycle while rsp_ch.ready is high. An
// accepted item passes through the staging register to the output register: the
// custom font and palette RAMs are read at the accept edge, then glyph and colors are
// resolved into the output register. A one-entry stage sits between input and output, so
// the next item is taken while the current one is still being emitted. All state updates
// (power, tick count, blink phase, table selects, border, custom RAM writes) happen at the
// accept edge, and the status fields of every beat show the state just after its item.
// Configuration (ticks per second) is taken at any time; csr_ch.ready is always high.
// No clearing pass is needed after reset.
module text_mode_display_controller #(
   parameter int SCREEN_CELLS  = 384,
   parameter int CELLS_PER_ROW = 32
) (
   input logic         clock,
   input logic         reset,
   tmdc_req_if.sink    req_ch,
   tmdc_rsp_if.source  rsp_ch,
   tmdc_csr_if.sink    csr_ch
);
   import tmdc_pkg::*;

   // row/column split of the cell index: multiply by a rounded-up reciprocal,
   // exact for every 9-bit position
   localparam int POS_W     = 9;
   localparam int ROW_SHIFT = $clog2(CELLS_PER_ROW);
   localparam int DIV_SHIFT = POS_W + ROW_SHIFT;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + CELLS_PER_ROW - 1) / CELLS_PER_ROW;
   localparam int PROD_W    = POS_W + DIV_SHIFT + 1;
   localparam logic [4:0]  ROW_LOW    = 5'(CELLS_PER_ROW);
   localparam logic [12:0] CELL_LIMIT = 13'(SCREEN_CELLS);

   // handshakes
   logic req_fire;
   logic rsp_fire;
   logic rsp_last;
   logic emit_load;

   // architectural state
   power_state_type power_ff, power_in;
   ticks_type       tick_ff, tick_in;
   ticks_type       tps_ff;
   logic            blink_ff, blink_in;
   logic            font_sel_ff, font_sel_in;
   logic            pal_sel_ff, pal_sel_in;
   pal_idx_type     border_ff, border_in;

   // custom tables and their registered read data
   word_type font_mem [FONT_WORDS];
   rgb_type  pal_mem [PALETTE_SIZE];
   word_type font_even_ff, font_odd_ff;
   rgb_type  pal_bg_ff, pal_fg_ff;

   // accept-side decode
   logic              draw_req;
   logic [PROD_W-1:0] div_prod;
   logic [6:0]        req_char;

   // stage between accept and output
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_draw_ff;
   logic [6:0]  s1_char_ff;
   pal_idx_type s1_bg_idx_ff, s1_fg_idx_ff;
   logic        s1_font_sel_ff, s1_pal_sel_ff;
   logic [4:0]  s1_quot_ff;
   logic [4:0]  s1_pos_lo_ff;
   logic        s1_active_ff, s1_blink_ff;
   pal_idx_type s1_border_ff;

   // resolved glyph, colors and screen cell
   word_type   glyph_even, glyph_odd;
   rgb_type    color_bg, color_fg;
   logic [4:0] cell_x;

   // output register: one beat per cycle while rsp_ch.ready is high
   logic        emit_valid_ff, emit_valid_in;
   logic [4:0]  emit_beat_ff;
   logic        emit_draw_ff;
   logic [31:0] emit_glyph_ff;
   rgb_type     emit_fg_ff, emit_bg_ff;
   logic [4:0]  emit_xcell_ff;
   logic [3:0]  emit_ycell_ff;
   logic        emit_active_ff, emit_blink_ff;
   pal_idx_type emit_border_ff;
   rgb_type     emit_color;

   // ---------------------------------------------------------------- handshakes
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign rsp_last  = !emit_draw_ff || (&emit_beat_ff);
   // output register takes the staged item when empty or on its final beat
   assign emit_load = s1_valid_ff && (!emit_valid_ff || (rsp_fire && rsp_last));
   // input stage frees up when it is empty or hands its item on this cycle
   assign req_ch.ready = !s1_valid_ff || emit_load;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------- state update at accept
   always_comb begin
      power_in    = power_ff;
      tick_in     = tick_ff;
      blink_in    = blink_ff;
      font_sel_in = font_sel_ff;
      pal_sel_in  = pal_sel_ff;
      border_in   = border_ff;
      if (req_fire) begin
         unique case (req_ch.req_type)
            REQ_COMMAND: begin
               unique case (req_ch.command)
                  CMD_MAP_SCREEN: begin
                     if (req_ch.operand == '0) begin
                        power_in = PWR_OFF;
                     end else if (power_ff == PWR_OFF) begin
                        power_in = PWR_STARTING;
                        tick_in  = '0;
                     end
                  end
                  CMD_MAP_FONT:    font_sel_in = (req_ch.operand != '0);
                  CMD_MAP_PALETTE: pal_sel_in  = (req_ch.operand != '0);
                  CMD_BORDER:      border_in   = req_ch.operand[3:0];
                  default: ;
               endcase
            end
            REQ_TICK: begin
               // period reached: advance power or blink, count restarts at one
               if (tick_ff >= tps_ff) begin
                  if (power_ff == PWR_ACTIVE) begin
                     blink_in = ~blink_ff;
                  end else if (power_ff == PWR_STARTING) begin
                     power_in = PWR_ACTIVE;
                  end
                  tick_in = ticks_type'(1);
               end else begin
                  tick_in = tick_ff + ticks_type'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff    <= PWR_OFF;
         tick_ff     <= '0;
         blink_ff    <= 1'b0;
         font_sel_ff <= 1'b0;
         pal_sel_ff  <= 1'b0;
         border_ff   <= '0;
         tps_ff      <= TICKS_RESET;
      end else begin
         power_ff    <= power_in;
         tick_ff     <= tick_in;
         blink_ff    <= blink_in;
         font_sel_ff <= font_sel_in;
         pal_sel_ff  <= pal_sel_in;
         border_ff   <= border_in;
         if (csr_ch.valid) begin
            tps_ff <= csr_ch.wdata;
         end
      end
   end

   // ---------------------------------------------------------------- render decision
   assign req_char = req_ch.operand[6:0];

   // hidden when blinking in the off phase, blank for char zero, off-screen or an inactive display
   assign draw_req = (req_ch.req_type == REQ_RENDER) && (power_ff == PWR_ACTIVE)
                   && ({4'd0, req_ch.position} < CELL_LIMIT)
                   && !(req_ch.operand[7] && !blink_ff)
                   && (req_char != '0);

   assign div_prod = PROD_W'(req_ch.position) * PROD_W'(DIV_MULT);

   // ---------------------------------------------------------------- custom tables
   always_ff @(posedge clock) begin
      if (req_fire && (req_ch.req_type == REQ_LOAD_FONT)) begin
         font_mem[req_ch.table_index] <= req_ch.operand;
      end
      if (req_fire) begin
         font_even_ff <= font_mem[{req_char, 1'b0}];
         font_odd_ff  <= font_mem[{req_char, 1'b1}];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_ch.req_type == REQ_LOAD_PALETTE)) begin
         pal_mem[req_ch.table_index[PAL_AW-1:0]] <= req_ch.operand[11:0];
      end
      if (req_fire) begin
         pal_bg_ff <= pal_mem[req_ch.operand[11:8]];
         pal_fg_ff <= pal_mem[req_ch.operand[15:12]];
      end
   end

   // ---------------------------------------------------------------- staging register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (emit_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // table selects are captured before the item; status after it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_draw_ff     <= draw_req;
         s1_char_ff     <= req_char;
         s1_bg_idx_ff   <= req_ch.operand[11:8];
         s1_fg_idx_ff   <= req_ch.operand[15:12];
         s1_font_sel_ff <= font_sel_ff;
         s1_pal_sel_ff  <= pal_sel_ff;
         s1_quot_ff     <= div_prod[DIV_SHIFT +: 5];
         s1_pos_lo_ff   <= req_ch.position[4:0];
         s1_active_ff   <= (power_in == PWR_ACTIVE);
         s1_blink_ff    <= blink_in;
         s1_border_ff   <= border_in;
      end
   end

   // ---------------------------------------------------------------- glyph and color
   assign glyph_even = s1_font_sel_ff ? font_even_ff : font_rom({s1_char_ff, 1'b0});
   assign glyph_odd  = s1_font_sel_ff ? font_odd_ff  : font_rom({s1_char_ff, 1'b1});
   assign color_bg   = s1_pal_sel_ff  ? pal_bg_ff    : palette_rom(s1_bg_idx_ff);
   assign color_fg   = s1_pal_sel_ff  ? pal_fg_ff    : palette_rom(s1_fg_idx_ff);

   // column of the cell, low bits only since pixel_x wraps at 7 bits
   assign cell_x = s1_pos_lo_ff - 5'(s1_quot_ff * ROW_LOW);

   // ---------------------------------------------------------------- output register
   always_comb begin
      emit_valid_in = emit_valid_ff;
      if (emit_load) begin
         emit_valid_in = 1'b1;
      end else if (rsp_fire && rsp_last) begin
         emit_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_valid_ff <= 1'b0;
         emit_beat_ff  <= '0;
      end else begin
         emit_valid_ff <= emit_valid_in;
         if (emit_load) begin
            emit_beat_ff <= '0;
         end else if (rsp_fire) begin
            emit_beat_ff <= emit_beat_ff + 5'd1;
         end
      end
   end

   // glyph bits go out lsb first, one per beat
   always_ff @(posedge clock) begin
      if (emit_load) begin
         emit_draw_ff   <= s1_draw_ff;
         emit_glyph_ff  <= {glyph_even, glyph_odd};
         emit_fg_ff     <= color_fg;
         emit_bg_ff     <= color_bg;
         emit_xcell_ff  <= cell_x;
         emit_ycell_ff  <= s1_quot_ff[3:0];
         emit_active_ff <= s1_active_ff;
         emit_blink_ff  <= s1_blink_ff;
         emit_border_ff <= s1_border_ff;
      end else if (rsp_fire) begin
         emit_glyph_ff <= {1'b0, emit_glyph_ff[31:1]};
      end
   end

   assign emit_color = emit_glyph_ff[0] ? emit_fg_ff : emit_bg_ff;

   // column offset runs 3 down to 0 (inverted beat bits), row offset 0 to 7
   assign rsp_ch.valid          = emit_valid_ff;
   assign rsp_ch.pixel_valid    = emit_draw_ff;
   assign rsp_ch.pixel_x        = emit_draw_ff ? {emit_xcell_ff, ~emit_beat_ff[4:3]} : '0;
   assign rsp_ch.pixel_y        = emit_draw_ff ? {emit_ycell_ff, emit_beat_ff[2:0]} : '0;
   assign rsp_ch.red            = emit_draw_ff ? widen_nibble(emit_color[11:8]) : '0;
   assign rsp_ch.green          = emit_draw_ff ? widen_nibble(emit_color[7:4]) : '0;
   assign rsp_ch.blue           = emit_draw_ff ? widen_nibble(emit_color[3:0]) : '0;
   assign rsp_ch.last           = rsp_last;
   assign rsp_ch.display_active = emit_active_ff;
   assign rsp_ch.blink_phase    = emit_blink_ff;
   assign rsp_ch.border_index   = emit_border_ff;

endmodule

### hdl/tmdc_checker.sv
// port-level checks of the text mode display controller and their bind
`include "assert_macros.svh"

module tmdc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  pixel_valid,
   input tmdc_pkg::coord_type   pixel_x,
   input tmdc_pkg::coord_type   pixel_y,
   input logic                  last,
   input logic                  display_active,
   input logic                  blink_phase,
   input tmdc_pkg::pal_idx_type border_index
);
   import tmdc_pkg::*;

   // output is empty right after reset
   `TMDC_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "beat right after reset")

   // a non-pixel beat is always a single marker
   `TMDC_ASSERT(a_marker_last, clock, reset, rsp_valid && !pixel_valid |-> last, "marker not last")

   // pixels only come from an active display
   `TMDC_ASSERT(a_pixel_active, clock, reset, rsp_valid && pixel_valid |-> display_active, "pixel while inactive")

   // a cell keeps streaming with unchanged status until its final beat
   `TMDC_ASSERT(a_cell_stream, clock, reset, rsp_valid && rsp_ready && pixel_valid && !last |=> rsp_valid && pixel_valid && $stable(blink_phase) && $stable(border_index), "cell stream broken")

   // stalled beat holds
   `TMDC_ASSERT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last), "stalled beat changed")

endmodule

bind text_mode_display_controller tmdc_checker u_tmdc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .pixel_valid    (rsp_ch.pixel_valid),
   .pixel_x        (rsp_ch.pixel_x),
   .pixel_y        (rsp_ch.pixel_y),
   .last           (rsp_ch.last),
   .display_active (rsp_ch.display_active),
   .blink_phase    (rsp_ch.blink_phase),
   .border_index   (rsp_ch.border_index)
);
